// ----- sv/pump_reply_frame_receiver_macros.svh -----
// ---------------------------------------------------------------------------
// Pump reply frame receiver assertion macros
// Shorthand for the concurrent checks at the end of the top level.
// ---------------------------------------------------------------------------
`ifndef PUMP_REPLY_FRAME_RECEIVER_MACROS_SVH
`define PUMP_REPLY_FRAME_RECEIVER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define PRFR_ASSERT_NOW(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("pump reply frame receiver check failed");

// Next-cycle implication, checked outside reset.
`define PRFR_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("pump reply frame receiver check failed");

`endif

// ----- sv/prfr_pkg.sv -----
// ---------------------------------------------------------------------------
// Pump reply frame receiver package
// Frame layout constants, status codes and the command decode.
// ---------------------------------------------------------------------------
package prfr_pkg;

   typedef logic [7:0]  byte_type;
   typedef logic [15:0] word_type;
   typedef logic [2:0]  status_type;

   typedef struct packed {
      status_type status;
      word_type   value;
   } report_type;

   localparam int unsigned FRAME_LEN = 8;
   localparam int unsigned SUM_LEN   = 6;
   localparam int unsigned COUNT_W   = $clog2(FRAME_LEN + 1);
   localparam int unsigned INDEX_W   = $clog2(FRAME_LEN);

   localparam logic OPC_BYTE = 1'b0;
   localparam logic OPC_TICK = 1'b1;

   localparam byte_type START_CODE     = 8'hCC;
   localparam byte_type END_CODE       = 8'hDD;
   localparam byte_type CMD_LAST_PLAIN = 8'h04;
   localparam byte_type CMD_SUSPEND    = 8'hFE;
   localparam byte_type CMD_RAW        = 8'hFF;

   localparam word_type GAP_RESET = 16'd100;
   localparam word_type IDLE_MAX  = 16'hFFFF;

   localparam status_type ST_NORMAL    = 3'd0;
   localparam status_type ST_SUSPENDED = 3'd5;
   localparam status_type ST_UNKNOWN   = 3'd6;

   // Command bytes 0 to 4 carry their own status code.
   function automatic report_type decode_report(byte_type cmd, word_type param);
      report_type rep;
      if (cmd <= CMD_LAST_PLAIN) begin
         rep.status = cmd[2:0];
         rep.value  = param;
      end else if (cmd == CMD_SUSPEND) begin
         rep.status = ST_SUSPENDED;
         rep.value  = param;
      end else if (cmd == CMD_RAW) begin
         rep.status = ST_UNKNOWN;
         rep.value  = param;
      end else begin
         rep.status = ST_UNKNOWN;
         rep.value  = '0;
      end
      return rep;
   endfunction

endpackage

// ----- sv/pump_reply_frame_receiver.sv -----
// ---------------------------------------------------------------------------
// Pump reply frame receiver
// Collects UART bytes into an 8-byte reply frame, closes the frame after an
// idle gap counted in ticks, checks it and reports status and value.
// ---------------------------------------------------------------------------
//  channel | ports                                    | direction
//  req     | req_valid/req_ready, opcode, rx_byte     | in
//  rsp     | rsp_valid/rsp_ready, frame_ok, status... | out
//  csr     | csr_wr_en, csr_wr_data (gap_ticks)       | in
//
// A request is registered on acceptance and processed from that register, so
// one request per cycle is sustained unless a stall holds it; the result is
// registered when the closing tick request is processed. Synchronous reset
// clears the counters, the kept status and sets gap_ticks to 100. Processing
// waits only while the result register is full and not being taken.
// ---------------------------------------------------------------------------
`include "pump_reply_frame_receiver_macros.svh"

module pump_reply_frame_receiver (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 req_opcode,
   input  prfr_pkg::byte_type   req_rx_byte,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic                 rsp_frame_ok,
   output prfr_pkg::status_type rsp_status,
   output prfr_pkg::word_type   rsp_value,
   input  logic                 csr_wr_en,
   input  prfr_pkg::word_type   csr_wr_data
);
   import prfr_pkg::*;

   // Input register
   logic        in_valid_ff, in_valid_in;
   logic        in_opcode_ff;
   byte_type    in_byte_ff;

   // Frame state
   byte_type             frame_ff [FRAME_LEN];
   logic [COUNT_W-1:0]   byte_count_ff, byte_count_in;
   word_type             sum_ff, sum_in;
   word_type             idle_ff, idle_in;
   status_type           pump_status_ff, pump_status_in;
   word_type             pump_value_ff, pump_value_in;
   word_type             gap_ff;

   // Result register
   logic        rsp_valid_ff, rsp_valid_in;
   logic        rsp_frame_ok_ff, rsp_frame_ok_in;
   status_type  rsp_status_ff;
   word_type    rsp_value_ff;

   logic        fire;
   logic        store_byte;
   logic        frame_end;
   logic        frame_good;
   word_type    idle_step;
   report_type  report;

   assign fire      = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || fire;

   assign store_byte = fire && (in_opcode_ff == OPC_BYTE) &&
                       (byte_count_ff < COUNT_W'(FRAME_LEN));
   assign idle_step  = (idle_ff == IDLE_MAX) ? idle_ff : idle_ff + 16'd1;
   assign frame_end  = fire && (in_opcode_ff == OPC_TICK) &&
                       (idle_step > gap_ff) && (byte_count_ff != '0);

   // Short frames fail on the count alone, before any stored byte matters.
   assign frame_good = (byte_count_ff == COUNT_W'(FRAME_LEN)) &&
                       (frame_ff[0] == START_CODE) &&
                       (frame_ff[5] == END_CODE) &&
                       ({frame_ff[7], frame_ff[6]} == sum_ff);
   assign report = decode_report(frame_ff[2], {frame_ff[3], frame_ff[4]});

   always_comb begin
      in_valid_in     = in_valid_ff;
      byte_count_in   = byte_count_ff;
      sum_in          = sum_ff;
      idle_in         = idle_ff;
      pump_status_in  = pump_status_ff;
      pump_value_in   = pump_value_ff;
      rsp_valid_in    = rsp_valid_ff;
      rsp_frame_ok_in = rsp_frame_ok_ff;

      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
      end else if (fire) begin
         in_valid_in = 1'b0;
      end

      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      if (fire && (in_opcode_ff == OPC_BYTE)) begin
         idle_in = '0;
         if (store_byte) begin
            byte_count_in = byte_count_ff + COUNT_W'(1);
            if (byte_count_ff < COUNT_W'(SUM_LEN)) begin
               sum_in = sum_ff + {8'h00, in_byte_ff};
            end
         end
      end else if (fire) begin
         idle_in = idle_step;
         if (frame_end) begin
            byte_count_in   = '0;
            sum_in          = '0;
            idle_in         = '0;
            rsp_valid_in    = 1'b1;
            rsp_frame_ok_in = frame_good;
            if (frame_good) begin
               pump_status_in = report.status;
               pump_value_in  = report.value;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         byte_count_ff  <= '0;
         sum_ff         <= '0;
         idle_ff        <= '0;
         pump_status_ff <= ST_NORMAL;
         pump_value_ff  <= '0;
         rsp_valid_ff   <= 1'b0;
         gap_ff         <= GAP_RESET;
      end else begin
         in_valid_ff    <= in_valid_in;
         byte_count_ff  <= byte_count_in;
         sum_ff         <= sum_in;
         idle_ff        <= idle_in;
         pump_status_ff <= pump_status_in;
         pump_value_ff  <= pump_value_in;
         rsp_valid_ff   <= rsp_valid_in;
         if (csr_wr_en) begin
            gap_ff <= csr_wr_data;
         end
      end
   end

   // Payload registers need no reset.
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_opcode_ff <= req_opcode;
         in_byte_ff   <= req_rx_byte;
      end
      if (store_byte) begin
         frame_ff[byte_count_ff[INDEX_W-1:0]] <= in_byte_ff;
      end
      if (frame_end) begin
         rsp_status_ff <= frame_good ? report.status : pump_status_ff;
         rsp_value_ff  <= frame_good ? report.value  : pump_value_ff;
      end
      rsp_frame_ok_ff <= rsp_frame_ok_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_frame_ok = rsp_frame_ok_ff;
   assign rsp_status   = rsp_status_ff;
   assign rsp_value    = rsp_value_ff;

   `PRFR_ASSERT_NOW(count_in_range, clock, reset, 1'b1, byte_count_ff <= COUNT_W'(FRAME_LEN))
   `PRFR_ASSERT_NEXT(frame_end_clears, clock, reset, frame_end,
                     rsp_valid_ff && (byte_count_ff == '0) && (idle_ff == '0))
   `PRFR_ASSERT_NEXT(held_request_stays, clock, reset, in_valid_ff && !fire,
                     in_valid_ff && $stable(in_opcode_ff) && $stable(in_byte_ff))

endmodule

// ----- tb/pump_reply_frame_receiver_tb.sv -----
// ---------------------------------------------------------------------------
// Pump reply frame receiver testbench
// Sends byte and tick requests with random pacing and a changing idle gap,
// predicts each frame report in a scoreboard and compares every report with
// the prediction, field by field.
// ---------------------------------------------------------------------------
module pump_reply_frame_receiver_tb;
   import prfr_pkg::*;

   localparam int ITEM_TARGET     = 1050;
   localparam int CYCLE_LIMIT     = 400000;
   localparam int SETTLE_CYCLES   = 8;
   localparam int HOLD_OFF_CYCLES = 160;
   localparam int MAX_PAUSE       = 8;

   // Byte positions within a reply frame.
   localparam int POS_START    = 0;
   localparam int POS_ID       = 1;
   localparam int POS_CMD      = 2;
   localparam int POS_PARAM_HI = 3;
   localparam int POS_PARAM_LO = 4;
   localparam int POS_END      = 5;
   localparam int POS_SUM_LO   = 6;
   localparam int POS_SUM_HI   = 7;

   localparam byte_type CMD_UNLISTED = 8'h80;

   typedef enum {FLAW_NONE, FLAW_START, FLAW_END, FLAW_SUM, FLAW_SHORT, FLAW_LONG} flaw_type;

   typedef struct {
      logic       ok;
      status_type status;
      word_type   value;
   } expected_report_type;

   class frame_report_board;
      byte_type            frame_store [FRAME_LEN];
      logic [COUNT_W-1:0]  byte_count;
      word_type            byte_sum;
      word_type            idle_count;
      word_type            gap_limit;
      status_type          held_status;
      word_type            held_value;
      expected_report_type due_reports [$];
      int                  errors;

      function new();
         byte_count  = '0;
         byte_sum    = '0;
         idle_count  = '0;
         gap_limit   = GAP_RESET;
         held_status = ST_NORMAL;
         held_value  = '0;
         errors      = 0;
      endfunction

      function int pending();
         return due_reports.size();
      endfunction

      // Tracks the frame state for one accepted request and queues the
      // report that a closing tick produces.
      function void note_request(logic opcode, byte_type rx_byte);
         expected_report_type rep;
         byte_type            cmd;
         word_type            param;
         if (opcode == OPC_BYTE) begin
            if (byte_count < FRAME_LEN) begin
               frame_store[byte_count[INDEX_W-1:0]] = rx_byte;
               if (byte_count < SUM_LEN) byte_sum = byte_sum + {8'h00, rx_byte};
               byte_count = byte_count + 1'b1;
            end
            idle_count = '0;
            return;
         end
         if (idle_count != IDLE_MAX) idle_count = idle_count + 1'b1;
         if (idle_count <= gap_limit || byte_count == '0) return;
         rep.ok = byte_count == FRAME_LEN
                  && frame_store[POS_START] == START_CODE
                  && frame_store[POS_END] == END_CODE
                  && {frame_store[POS_SUM_HI], frame_store[POS_SUM_LO]} == byte_sum;
         if (rep.ok) begin
            cmd   = frame_store[POS_CMD];
            param = {frame_store[POS_PARAM_HI], frame_store[POS_PARAM_LO]};
            if (cmd <= CMD_LAST_PLAIN) begin
               held_status = cmd[2:0];
               held_value  = param;
            end else if (cmd == CMD_SUSPEND) begin
               held_status = ST_SUSPENDED;
               held_value  = param;
            end else if (cmd == CMD_RAW) begin
               held_status = ST_UNKNOWN;
               held_value  = param;
            end else begin
               // An unrecognised command reports no parameter.
               held_status = ST_UNKNOWN;
               held_value  = '0;
            end
         end
         rep.status = held_status;
         rep.value  = held_value;
         due_reports.push_back(rep);
         byte_count = '0;
         byte_sum   = '0;
         idle_count = '0;
      endfunction

      function void compare_field(string name, logic [15:0] want, logic [15:0] got);
         if (got !== want) begin
            $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
            errors++;
         end
      endfunction

      function void check_report(logic ok, status_type status, word_type value);
         expected_report_type want;
         if (due_reports.size() == 0) begin
            $display("%0t: unexpected report, frame_ok %0b status %0d value %0h",
                     $time, ok, status, value);
            errors++;
            return;
         end
         want = due_reports.pop_front();
         compare_field("frame_ok", want.ok, ok);
         compare_field("status", want.status, status);
         compare_field("value", want.value, value);
      endfunction
   endclass

   logic       clock       = 1'b0;
   logic       reset       = 1'b1;
   logic       req_valid   = 1'b0;
   logic       req_ready;
   logic       req_opcode  = OPC_BYTE;
   byte_type   req_rx_byte = '0;
   logic       rsp_valid;
   logic       rsp_ready   = 1'b0;
   logic       rsp_frame_ok;
   status_type rsp_status;
   word_type   rsp_value;
   logic       csr_wr_en   = 1'b0;
   word_type   csr_wr_data = '0;

   frame_report_board board = new();
   word_type gap_now          = GAP_RESET;
   int       items_sent       = 0;
   int       cycle_count      = 0;
   bit       steady_sender    = 1'b0;
   bit       hold_off_pending = 1'b0;

   pump_reply_frame_receiver dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_opcode   (req_opcode),
      .req_rx_byte  (req_rx_byte),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_frame_ok (rsp_frame_ok),
      .rsp_status   (rsp_status),
      .rsp_value    (rsp_value),
      .csr_wr_en    (csr_wr_en),
      .csr_wr_data  (csr_wr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("pump_reply_frame_receiver_tb NOT OK");
         $finish;
      end
   end

   task automatic send_request(logic opcode, byte_type rx_byte);
      int pause;
      pause = steady_sender ? 0 : $urandom_range(0, MAX_PAUSE);
      if (pause > 0) begin
         req_valid <= 1'b0;
         repeat (pause) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_opcode  <= opcode;
      req_rx_byte <= rx_byte;
      do @(posedge clock); while (req_ready !== 1'b1);
      board.note_request(opcode, rx_byte);
      items_sent++;
   endtask

   // The byte field of a tick request is random, since the block ignores it.
   task automatic send_ticks(int count);
      repeat (count) send_request(OPC_TICK, byte_type'($urandom));
   endtask

   task automatic send_frame(byte_type cmd, word_type param, flaw_type flaw);
      byte_type frm [FRAME_LEN];
      word_type total;
      int       len;
      frm[POS_START]    = START_CODE;
      frm[POS_ID]       = byte_type'($urandom);
      frm[POS_CMD]      = cmd;
      frm[POS_PARAM_HI] = param[15:8];
      frm[POS_PARAM_LO] = param[7:0];
      frm[POS_END]      = END_CODE;
      total = '0;
      for (int i = 0; i < SUM_LEN; i++) total = total + {8'h00, frm[i]};
      frm[POS_SUM_LO] = total[7:0];
      frm[POS_SUM_HI] = total[15:8];
      len = FRAME_LEN;
      case (flaw)
         FLAW_START: frm[POS_START] ^= byte_type'($urandom_range(1, 255));
         FLAW_END:   frm[POS_END] ^= byte_type'($urandom_range(1, 255));
         FLAW_SUM:   frm[POS_SUM_LO + $urandom_range(0, 1)] ^= byte_type'($urandom_range(1, 255));
         FLAW_SHORT: len = $urandom_range(1, FRAME_LEN - 1);
         FLAW_LONG:  len = FRAME_LEN + $urandom_range(1, 4);
         default: ;
      endcase
      for (int i = 0; i < len; i++)
         send_request(OPC_BYTE, i < FRAME_LEN ? frm[i] : byte_type'($urandom));
   endtask

   task automatic send_sequence();
      byte_type cmd;
      flaw_type flaw;
      int       pick;
      int       ticks;
      pick = $urandom_range(0, 99);
      case ($urandom_range(0, 7))
         0, 1, 2, 3: cmd = byte_type'($urandom_range(0, CMD_LAST_PLAIN));
         4:          cmd = CMD_SUSPEND;
         5:          cmd = CMD_RAW;
         default:    cmd = byte_type'($urandom_range(CMD_LAST_PLAIN + 1, CMD_SUSPEND - 1));
      endcase
      if (pick < 70) flaw = FLAW_NONE;
      else if (pick < 80) flaw = flaw_type'($urandom_range(FLAW_START, FLAW_SUM));
      else if (pick < 87) flaw = FLAW_SHORT;
      else flaw = FLAW_LONG;
      if (pick >= 94) begin
         repeat ($urandom_range(1, 6))
            send_request(logic'($urandom_range(0, 1)), byte_type'($urandom));
      end else begin
         send_frame(cmd, word_type'($urandom), flaw);
         // Too few ticks let the next frame run on into this one.
         if ($urandom_range(0, 9) == 0) ticks = $urandom_range(0, gap_now);
         else ticks = int'(gap_now) + 1 + $urandom_range(0, 1);
         send_ticks(ticks);
      end
   endtask

   // Waits until every report has arrived and the block has gone quiet.
   task automatic settle();
      req_valid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_gap(word_type limit);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= limit;
      @(posedge clock);
      csr_wr_en       <= 1'b0;
      board.gap_limit = limit;
      gap_now         = limit;
   endtask

   initial begin : report_side
      int pause;
      int taken;
      taken = 0;
      wait (reset == 1'b0);
      forever begin
         // Alternate stretches of eager and hesitant acceptance.
         pause = ((taken / 32) % 2 == 1) ? 0 : $urandom_range(0, MAX_PAUSE);
         if (hold_off_pending) begin
            hold_off_pending = 1'b0;
            pause = HOLD_OFF_CYCLES;
         end
         if (pause > 0) begin
            rsp_ready <= 1'b0;
            repeat (pause) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid === 1'b1 && rsp_ready === 1'b1));
         board.check_report(rsp_frame_ok, rsp_status, rsp_value);
         taken++;
      end
   end

   initial begin : request_side
      int phase;
      phase = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // The gap after reset: a clean frame closes only once the tick count passes it.
      send_frame(CMD_LAST_PLAIN, 16'h1234, FLAW_NONE);
      send_ticks(int'(GAP_RESET) + 1);
      settle();
      set_gap('0);

      // Bytes past the eighth are dropped; suspended reply with an all-ones parameter.
      send_frame(CMD_SUSPEND, 16'hFFFF, FLAW_LONG);
      send_ticks(1);
      // A single byte is a short frame; a further tick with nothing pending is silent.
      send_request(OPC_BYTE, 8'hFF);
      send_ticks(2);
      send_frame(CMD_UNLISTED, 16'h0000, FLAW_NONE);
      send_ticks(1);
      // At the largest gap a frame never ends, until the gap is lowered again.
      settle();
      set_gap(IDLE_MAX);
      send_request(OPC_BYTE, 8'h00);
      send_ticks(3);
      settle();
      set_gap('0);
      send_ticks(1);

      while (items_sent < ITEM_TARGET) begin
         settle();
         if ($urandom_range(0, 9) == 0) set_gap(word_type'($urandom_range(4, 12)));
         else set_gap(word_type'($urandom_range(0, 3)));
         steady_sender = phase == 2 || $urandom_range(0, 2) == 0;
         // One phase keeps requests flowing while the report side holds off.
         if (phase == 2) hold_off_pending = 1'b1;
         repeat (phase == 2 ? 24 : $urandom_range(4, 10)) send_sequence();
         phase++;
      end
      settle();

      if (board.errors == 0) begin
         $display("pump_reply_frame_receiver_tb OK");
      end else begin
         $display("pump_reply_frame_receiver_tb NOT OK");
      end
      $finish;
   end

endmodule
